### design/sha_pkg.sv
// package for the sha-256 stream hasher: types, constants and a rotate function
package sha_pkg;

   localparam logic [31:0] K_ROUND [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] K_INIT [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;
   localparam int QUEUE_DEPTH = 2;

   // one block handed from the packer to the compression engine
   typedef struct packed {
      logic [511:0] block;
      logic         final_blk;
   } block_job_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

### design/sha_front.sv
// byte packer: builds 64-byte blocks, pads the final one and queues block jobs
module sha_front import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_byte,
   input  logic          in_has,
   input  logic          in_last,
   output logic          job_valid,
   input  logic          job_ready,
   output block_job_type job
);

   typedef enum logic [2:0] {
      ST_FILL  = 3'b001,
      ST_PAD2  = 3'b010,
      ST_LEN   = 3'b100
   } state_type;

   state_type     state_ff, state_in;
   logic [511:0]  blk_ff, blk_in;
   logic [5:0]    pos_ff, pos_in;
   logic [63:0]   len_ff, len_in;
   block_job_type q_ff [QUEUE_DEPTH];
   logic [1:0]    cnt_ff;
   logic          rd_ff, wr_ff;
   logic          push;
   block_job_type push_job;
   logic          pop;
   logic          q_space;

   assign q_space = (cnt_ff < 2'(QUEUE_DEPTH));
   assign in_ready = (state_ff == ST_FILL) && q_space;
   assign pop = job_valid && job_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ff];

   function automatic logic [511:0] put_byte(input logic [511:0] b, input logic [5:0] p,
                                             input logic [7:0] v);
      logic [511:0] r;
      r = b;
      r[511 - 8 * p -: 8] = v;
      return r;
   endfunction

   always_comb begin
      logic [511:0] b;
      logic [5:0]   p;
      state_in = state_ff;
      blk_in = blk_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      push = 1'b0;
      push_job = '{block: blk_ff, final_blk: 1'b0};
      b = blk_ff;
      p = pos_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (in_valid && in_ready) begin
               if (in_has) begin
                  b = put_byte(b, p, in_byte);
                  len_in = len_ff + 64'd8;
                  p = p + 6'd1;
                  if (p == 6'd0) begin
                     push = 1'b1;
                     push_job = '{block: b, final_blk: 1'b0};
                  end
               end
               blk_in = b;
               pos_in = p;
               if (in_last) begin
                  if (push) begin
                     state_in = ST_LEN;
                  end else begin
                     for (int i = 0; i < 64; i++) begin
                        if (6'(i) == p) b = put_byte(b, 6'(i), PAD_BYTE);
                        else if (6'(i) > p) b = put_byte(b, 6'(i), 8'h00);
                     end
                     blk_in = b;
                     if (p >= LEN_POS) begin
                        push = 1'b1;
                        push_job = '{block: b, final_blk: 1'b0};
                        state_in = ST_PAD2;
                     end else begin
                        b[63:0] = len_in;
                        push = 1'b1;
                        push_job = '{block: b, final_blk: 1'b1};
                        pos_in = 6'd0;
                        len_in = 64'd0;
                     end
                  end
               end
            end
         end
         ST_LEN: begin
            // full block just queued, padding block starts with the marker byte
            if (q_space) begin
               b = '0;
               b[511 -: 8] = PAD_BYTE;
               b[63:0] = len_ff;
               push = 1'b1;
               push_job = '{block: b, final_blk: 1'b1};
               pos_in = 6'd0;
               len_in = 64'd0;
               state_in = ST_FILL;
            end
         end
         ST_PAD2: begin
            if (q_space) begin
               b = '0;
               b[63:0] = len_ff;
               push = 1'b1;
               push_job = '{block: b, final_blk: 1'b1};
               pos_in = 6'd0;
               len_in = 64'd0;
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (push) q_ff[wr_ff] <= push_job;
      if (reset) begin
         state_ff <= ST_FILL;
         pos_ff <= '0;
         len_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> q_space) else $error("block queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_pad_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FILL) |-> !in_ready) else $error("input taken during padding");
`endif

endmodule

### design/sha_core.sv
// compression engine: one round per cycle, chaining update and digest output
module sha_core import sha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   output logic          job_ready,
   input  block_job_type job,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [31:0]   out_word,
   output logic [2:0]    out_index,
   output logic          out_last
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type    state_ff;
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [5:0]   rnd_ff;
   logic         fin_ff;
   logic [2:0]   idx_ff;
   logic [31:0]  t1, t2, wnew, s0w, s1w;

   assign job_ready = (state_ff == ST_IDLE);
   assign out_valid = (state_ff == ST_OUT);
   assign out_word = h_ff[idx_ff];
   assign out_index = idx_ff;
   assign out_last = (idx_ff == 3'd7);

   always_comb begin
      t1 = v_ff[7] + (ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + K_ROUND[rnd_ff] + w_ff[0];
      t2 = (ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0w = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0w + w_ff[9] + s1w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff <= '0;
         idx_ff <= '0;
         fin_ff <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= K_INIT[i];
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  for (int i = 0; i < 16; i++) w_ff[i] <= job.block[511 - 32 * i -: 32];
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  fin_ff <= job.final_blk;
                  rnd_ff <= '0;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
               w_ff[15] <= wnew;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               idx_ff <= '0;
               state_ff <= fin_ff ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
               if (out_ready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= K_INIT[i];
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> state_ff == ST_ADD)
      else $error("round counter did not end compression");
   a_out_only_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |=> (state_ff == ST_OUT) == $past(fin_ff))
      else $error("digest output without final block");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> $stable(idx_ff))
      else $error("digest index moved under stall");
`endif

endmodule

### design/sha256_stream_hash.sv
// top level of the sha-256 stream hasher
//  channel  direction  fields (tdata/tuser)
//  req      in         tdata: data_byte[7:0], has_byte[8]; tlast: last
//  rsp      out        tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast: last_word
// bytes are taken one per cycle while the block queue has room and no padding block is pending
// each 64-byte block is loaded, run through all rounds in the compression engine, one round a cycle, then added in
// the digest leaves as eight words after the final block; a message ending
// at 56 bytes or more in its block needs one extra padding block
// reset is synchronous; the core returns to the standard initial values
module sha256_stream_hash import sha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte, has_byte, zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast
);

   logic          job_valid, job_ready;
   block_job_type job;

   sha_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata[7:0]), .in_has(req_tdata[8]), .in_last(req_tlast),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   sha_core u_core (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(rsp_tdata), .out_index(rsp_tuser), .out_last(rsp_tlast)
   );

endmodule
